FILE: rtl/order1_byte_frequency_model_unit_defines.svh
// Assertion macros for the order-1 byte frequency model
`ifndef ORDER1_BYTE_FREQUENCY_MODEL_UNIT_DEFINES_SVH
`define ORDER1_BYTE_FREQUENCY_MODEL_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define OBFM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("obfm assertion failed");
`define OBFM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("obfm assertion failed");
`else
`define OBFM_ASSERT_IMP(label, ante, cons)
`define OBFM_ASSERT_NXT(label, ante, cons)
`endif
`endif

FILE: rtl/obfm_pkg.sv
package obfm_pkg;

  localparam logic FUNC_QUERY  = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  localparam logic [14:0] COUNT_ONE       = 15'd1;
  localparam logic [15:0] COUNT_MAX       = 16'd32767;
  localparam logic [16:0] TOTAL_MAX       = 17'd65535;
  localparam logic [15:0] THRESHOLD_RESET = 16'd16384;
  localparam logic [15:0] PROB_MAX        = 16'hFFFF;

  // one request after index clamping
  typedef struct packed {
    logic       func;
    logic [7:0] row;
    logic [7:0] sym;
  } req_t;

endpackage

FILE: rtl/obfm_front.sv
module obfm_front
  import obfm_pkg::*;
#(
  parameter int SYMBOLS = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       func,
  input  logic [7:0] context_byte,
  input  logic [7:0] symbol,
  output logic       q_valid,
  output req_t       q_data,
  input  logic       q_pop
);

  localparam logic [8:0] SYM_LIM  = 9'(SYMBOLS);
  localparam logic [7:0] SYM_LAST = 8'(SYMBOLS - 1);

  req_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  req_t       req_in;

  always_comb begin
    req_in.func = func;
    req_in.row  = ({1'b0, context_byte} >= SYM_LIM) ? SYM_LAST : context_byte;
    req_in.sym  = ({1'b0, symbol} >= SYM_LIM) ? SYM_LAST : symbol;
  end

  assign in_stall = (fill == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign q_data   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: rtl/obfm_div.sv
module obfm_div
  import obfm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [14:0] count,
  input  logic [15:0] total,
  output logic        done,
  output logic [15:0] quot
);

  // restoring division of count<<16 by total, one bit per cycle
  logic [30:0] dvd;
  logic [30:0] q;
  logic [15:0] rem;
  logic [15:0] den;
  logic [4:0]  steps;
  logic        busy;
  logic [16:0] rem_sh;
  logic        fits;
  logic [30:0] q_next;

  always_comb begin
    rem_sh = {rem, dvd[30]};
    fits   = (rem_sh >= {1'b0, den});
    q_next = {q[29:0], fits};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {count, 16'd0};
      den <= total;
      rem <= 16'd0;
      q   <= 31'd0;
    end else if (busy) begin
      dvd <= {dvd[29:0], 1'b0};
      rem <= fits ? 16'(rem_sh - {1'b0, den}) : rem_sh[15:0];
      q   <= q_next;
      if (steps == 5'd1) begin
        if (den == 16'd0) begin
          quot <= 16'd0;
        end else if (q_next[30:16] != 15'd0) begin
          quot <= PROB_MAX;
        end else begin
          quot <= q_next[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= 5'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= 5'd31;
      end else if (busy) begin
        steps <= steps - 5'd1;
        if (steps == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/obfm_core.sv
module obfm_core
  import obfm_pkg::*;
#(
  parameter int SYMBOLS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] threshold,
  input  logic        q_valid,
  input  req_t        q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] symbol_count,
  output logic [15:0] context_total,
  output logic [15:0] probability,
  output logic        rescaled
);

  localparam int SW    = $clog2(SYMBOLS);
  localparam int AW    = 2 * SW;
  localparam logic [SW:0]   SYM_N    = (SW + 1)'(SYMBOLS);
  localparam logic [SW:0]   IDX_ONE  = (SW + 1)'(1);
  localparam logic [AW-1:0] CLR_ONE  = AW'(1);
  localparam logic [SW-1:0] SYM_LAST = SW'(SYMBOLS - 1);
  localparam logic [15:0]   TOT_INIT = 16'(SYMBOLS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_START = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;

  logic [14:0] count_mem [0:(1 << AW) - 1];
  logic [15:0] total_mem [0:(1 << SW) - 1];

  logic          cm_we;
  logic [AW-1:0] cm_wa;
  logic [14:0]   cm_wd;
  logic [AW-1:0] cm_ra;
  logic [14:0]   cm_rd;
  logic          tm_we;
  logic [SW-1:0] tm_wa;
  logic [15:0]   tm_wd;
  logic [SW-1:0] tm_ra;
  logic [15:0]   tm_rd;

  logic [2:0]    state;
  logic [AW-1:0] clr_addr;
  logic          func_r;
  logic [SW-1:0] row_r;
  logic [SW-1:0] sym_r;
  logic [14:0]   cnt_r;
  logic [15:0]   tot_r;
  logic          resc_r;
  logic [SW:0]   idx;
  logic          rd_vld;
  logic [SW-1:0] rd_idx;
  logic [16:0]   sum;

  logic [15:0]   c_inc;
  logic [16:0]   t_inc;
  logic          need_rescale;
  logic [14:0]   half_c;
  logic [16:0]   sum_next;
  logic          issue;
  logic          div_start;
  logic          div_done;
  logic [15:0]   div_quot;

  always_comb begin
    c_inc        = {1'b0, cm_rd} + 16'd1;
    t_inc        = {1'b0, tm_rd} + 17'd1;
    need_rescale = (t_inc >= {1'b0, threshold}) || (c_inc >= COUNT_MAX) ||
                   (t_inc >= TOTAL_MAX);
    half_c       = {1'b0, cm_rd[14:1]} | COUNT_ONE;
    sum_next     = sum + {2'b00, half_c};
    issue        = (state == S_SCAN) && (idx < SYM_N);
    q_pop        = (state == S_IDLE) && q_valid && !out_valid;
    div_start    = (state == S_START);
  end

  always_comb begin
    cm_we = 1'b0;
    cm_wa = {row_r, sym_r};
    cm_wd = c_inc[14:0];
    cm_ra = {q_data.row[SW-1:0], q_data.sym[SW-1:0]};
    tm_we = 1'b0;
    tm_wa = row_r;
    tm_wd = t_inc[15:0];
    tm_ra = q_data.row[SW-1:0];
    case (state)
      S_CLEAR: begin
        cm_we = 1'b1;
        cm_wa = clr_addr;
        cm_wd = COUNT_ONE;
        tm_we = (clr_addr[SW-1:0] == '0);
        tm_wa = clr_addr[AW-1:SW];
        tm_wd = TOT_INIT;
      end
      S_READ: begin
        cm_we = (func_r == FUNC_UPDATE);
        tm_we = (func_r == FUNC_UPDATE);
      end
      S_SCAN: begin
        cm_ra = {row_r, idx[SW-1:0]};
        cm_we = rd_vld;
        cm_wa = {row_r, rd_idx};
        cm_wd = half_c;
        tm_we = rd_vld && (rd_idx == SYM_LAST);
        tm_wd = sum_next[15:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cm_we) begin
      count_mem[cm_wa] <= cm_wd;
    end
    cm_rd <= count_mem[cm_ra];
  end

  always_ff @(posedge clk) begin
    if (tm_we) begin
      total_mem[tm_wa] <= tm_wd;
    end
    tm_rd <= total_mem[tm_ra];
  end

  obfm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .count (cnt_r),
    .total (tot_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // request payload and working registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      func_r <= q_data.func;
      row_r  <= q_data.row[SW-1:0];
      sym_r  <= q_data.sym[SW-1:0];
    end
    if (state == S_READ) begin
      if (func_r == FUNC_UPDATE) begin
        cnt_r  <= c_inc[14:0];
        tot_r  <= t_inc[15:0];
        resc_r <= need_rescale;
      end else begin
        cnt_r  <= cm_rd;
        tot_r  <= tm_rd;
        resc_r <= 1'b0;
      end
      sum    <= 17'd0;
      idx    <= '0;
      rd_idx <= '0;
    end
    if (state == S_SCAN) begin
      if (issue) begin
        idx <= idx + IDX_ONE;
      end
      rd_idx <= idx[SW-1:0];
      if (rd_vld) begin
        sum <= sum_next;
        if (rd_idx == sym_r) begin
          cnt_r <= half_c;
        end
        if (rd_idx == SYM_LAST) begin
          tot_r <= sum_next[15:0];
        end
      end
    end
    if (div_done) begin
      symbol_count  <= cnt_r;
      context_total <= tot_r;
      probability   <= div_quot;
      rescaled      <= resc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + CLR_ONE;
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if ((func_r == FUNC_UPDATE) && need_rescale) begin
            state <= S_SCAN;
          end else begin
            state <= S_START;
          end
        end
        S_SCAN: begin
          if (rd_vld && (rd_idx == SYM_LAST)) begin
            state <= S_START;
          end
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/order1_byte_frequency_model_unit.sv
// From request accept to out_valid the request leaves the queue and reads the tables,
//   the divider is launched and runs its 31 steps, and the result is registered.
// An update that rescales its row also walks the whole row before the divider starts.
// Requests are taken one at a time: the next leaves the queue only after the last
//   result has been accepted.
// Reset: synchronous; threshold back to 16384, then a clear of all 4**clog2(SYMBOLS) counts.
`include "order1_byte_frequency_model_unit_defines.svh"
module order1_byte_frequency_model_unit
  import obfm_pkg::*;
#(
  parameter int SYMBOLS = 256
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: rescale threshold
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [7:0]  context_byte,
  input  logic [7:0]  symbol,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] symbol_count,
  output logic [15:0] context_total,
  output logic [15:0] probability,
  output logic        rescaled
);

  // Row total at which a context row is halved.
  logic [15:0] threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      threshold <= cfg_wr_data;
    end
  end

  // Front end: clamps indexes and buffers two requests so the input side
  // keeps moving while the back end is busy or the result is stalled.
  logic q_valid;
  req_t q_data;
  logic q_pop;

  obfm_front #(
    .SYMBOLS (SYMBOLS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .context_byte (context_byte),
    .symbol       (symbol),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop)
  );

  // Back end: table read-modify-write, row rescale walk, divider, result register.
  obfm_core #(
    .SYMBOLS (SYMBOLS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .threshold     (threshold),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .symbol_count  (symbol_count),
    .context_total (context_total),
    .probability   (probability),
    .rescaled      (rescaled)
  );

  // A count can never exceed the total of its row.
  `OBFM_ASSERT_IMP(a_count_le_total, out_valid, {1'b0, symbol_count} <= context_total)
  // Totals are at least one per symbol, never zero.
  `OBFM_ASSERT_IMP(a_total_nonzero, out_valid, context_total != 16'd0)
  // A rescaled row is far below the saturation limit.
  `OBFM_ASSERT_IMP(a_rescale_total, out_valid && rescaled, context_total != 16'hFFFF)
  // The back end never pops while a result waits.
  `OBFM_ASSERT_NXT(a_pop_blocked, out_valid && out_stall, !q_pop)

endmodule
